// ===== src/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

  localparam int unsigned MEM_BLOCKS_DEF = 1024;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned START_W        = 10;

  localparam logic [COUNT_W-1:0] RESERVED_RESET = COUNT_W'(64);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [COUNT_W-1:0] block_count;
    logic [START_W-1:0] free_start;
  } req_t;

  typedef struct packed {
    logic [START_W-1:0] start_block;
    logic               failed;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/ffba_if.sv =====
`default_nettype none

interface ffba_req_if import ffba_pkg::*;;
  logic               valid;
  logic               ready;
  logic               op;
  logic [COUNT_W-1:0] block_count;
  logic [START_W-1:0] free_start;

  modport source (output valid, output op, output block_count, output free_start,
                  input ready);
  modport sink   (input valid, input op, input block_count, input free_start,
                  output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*;;
  logic               valid;
  logic               ready;
  logic [START_W-1:0] start_block;
  logic               failed;

  modport source (output valid, output start_block, output failed, input ready);
  modport sink   (input valid, input start_block, input failed, output ready);
endinterface

`default_nettype wire

// ===== src/first_fit_block_allocator.sv =====
// Free of n blocks clears the map from free_start, clipped at the store's end; out of range: no write.
// Allocate of n blocks: first fit, found by the one-entry-per-cycle map scan below limit
// (limit = MEM_BLOCKS - reserved_blocks, or 0); a size of zero or above limit fails unscanned.
// One word is worked on at a time; a finished result waits in the output register.
// After reset the map is swept free before the first word is taken; reserved_blocks resets to 64.
`default_nettype none

module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int unsigned MEM_BLOCKS = MEM_BLOCKS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i,
  ffba_req_if.sink                req_i,
  ffba_rsp_if.source              rsp_o
);

  logic [COUNT_W-1:0] reserved_q;
  logic               out_valid_q;
  rsp_t               out_q;
  req_t               req;
  rsp_t               res;
  logic               res_valid, res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= RESERVED_RESET;
    end else if (cfg_we_i) begin
      reserved_q <= cfg_wdata_i;
    end
  end

  assign req = '{op: op_e'(req_i.op), block_count: req_i.block_count,
                 free_start: req_i.free_start};

  ffba_engine #(
    .MEM_BLOCKS(MEM_BLOCKS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserved_i  (reserved_q),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.start_block = out_q.start_block;
  assign rsp_o.failed      = out_q.failed;

endmodule

`default_nettype wire

// ===== src/ffba_engine.sv =====
`default_nettype none

module ffba_engine import ffba_pkg::*; #(
  parameter int unsigned MEM_BLOCKS = MEM_BLOCKS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [COUNT_W-1:0] reserved_i,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire req_t               req_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output rsp_t                    res_o
);

  localparam int unsigned IDX_W  = $clog2(MEM_BLOCKS);
  localparam int unsigned CNT_W  = $clog2(MEM_BLOCKS + 1);
  localparam int unsigned WIDE_W = (CNT_W > 12) ? CNT_W : 12;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic [COUNT_W-1:0] run_q, run_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]   limit_q, limit_d;
  logic [CNT_W-1:0]   wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]   wr_end_q, wr_end_d;
  logic               wr_val_q, wr_val_d;
  rsp_t               res_q, res_d;

  logic               map_mem [MEM_BLOCKS];
  logic               rdata_q;
  logic               mem_we, mem_re;

  logic [WIDE_W-1:0]  wide_res, wide_lim, wide_cnt, wide_first, wide_fend, wide_clip;
  logic               alloc_ok, free_any;
  logic [CNT_W-1:0]   found_end, found_start;

  assign mem_we = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
  assign mem_re = (state_q == ST_SCAN) && (rd_idx_q < limit_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[wr_idx_q[IDX_W-1:0]] <= wr_val_q;
    end
    if (mem_re) begin
      rdata_q <= map_mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  always_comb begin
    wide_res   = WIDE_W'(reserved_i);
    wide_lim   = (wide_res >= WIDE_W'(MEM_BLOCKS)) ? '0 : WIDE_W'(MEM_BLOCKS) - wide_res;
    wide_cnt   = WIDE_W'(req_i.block_count);
    wide_first = WIDE_W'(req_i.free_start);
    wide_fend  = wide_first + wide_cnt;
    wide_clip  = (wide_fend > WIDE_W'(MEM_BLOCKS)) ? WIDE_W'(MEM_BLOCKS) : wide_fend;
    alloc_ok   = (wide_cnt != '0) && (wide_cnt <= wide_lim);
    free_any   = wide_first < wide_clip;
    found_end   = CNT_W'(pend_idx_q) + CNT_W'(1);
    found_start = found_end - CNT_W'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      run_q    <= '0;
      wr_idx_q <= '0;
      wr_end_q <= '0;
      wr_val_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
      run_q    <= run_d;
      wr_idx_q <= wr_idx_d;
      wr_end_q <= wr_end_d;
      wr_val_q <= wr_val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    cnt_q      <= cnt_d;
    limit_q    <= limit_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    run_d       = run_q;
    cnt_d       = cnt_q;
    limit_d     = limit_q;
    wr_idx_d    = wr_idx_q;
    wr_end_d    = wr_end_q;
    wr_val_d    = wr_val_q;
    res_d       = res_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        wr_idx_d = wr_idx_q + CNT_W'(1);
        if (wr_idx_q == CNT_W'(MEM_BLOCKS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_i.op == OP_FREE) begin
            res_d = '{start_block: '0, failed: 1'b0};
            if (free_any) begin
              wr_idx_d = CNT_W'(wide_first);
              wr_end_d = CNT_W'(wide_clip);
              wr_val_d = 1'b0;
              state_d  = ST_WRITE;
            end else begin
              state_d = ST_DONE;
            end
          end else if (alloc_ok) begin
            cnt_d    = req_i.block_count;
            limit_d  = CNT_W'(wide_lim);
            rd_idx_d = '0;
            pend_d   = 1'b0;
            run_d    = '0;
            state_d  = ST_SCAN;
          end else begin
            res_d   = '{start_block: '0, failed: 1'b1};
            state_d = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        pend_d     = mem_re;
        pend_idx_d = rd_idx_q[IDX_W-1:0];
        if (mem_re) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        if (pend_q) begin
          if (!rdata_q) begin
            if (run_q + COUNT_W'(1) == cnt_q) begin
              wr_idx_d = found_start;
              wr_end_d = found_end;
              wr_val_d = 1'b1;
              res_d    = '{start_block: START_W'(found_start), failed: 1'b0};
              pend_d   = 1'b0;
              state_d  = ST_WRITE;
            end else begin
              run_d = run_q + COUNT_W'(1);
            end
          end else begin
            run_d = '0;
          end
        end else if (!mem_re) begin
          res_d   = '{start_block: '0, failed: 1'b1};
          state_d = ST_DONE;
        end
      end

      ST_WRITE: begin
        wr_idx_d = wr_idx_q + CNT_W'(1);
        if (wr_idx_q + CNT_W'(1) == wr_end_q) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re)
    else $error("Map read and write in the same cycle.");

  a_run_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (run_q < cnt_q))
    else $error("Free run reached the request size without being taken.");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (wr_idx_q < wr_end_q))
    else $error("Write pointer ran past the end of the run.");

  a_mark_below_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && wr_val_q) |-> (wr_end_q <= limit_q))
    else $error("Allocation reached into the reserved area.");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q != ST_IDLE))
    else $error("Accepted word did not start any work.");

endmodule

`default_nettype wire
